// ===== sv/mkp_pkg.sv =====
// shared types, constants and glyph table for the keypad scanner and display
`timescale 1ns / 1ps
package mkp_pkg;

  localparam int DEFAULT_NUM_DIGITS = 6;
  localparam int DEFAULT_NUM_ROWS   = 4;
  localparam int COLS               = 4;

  localparam logic [7:0] HIST_RELEASED = 8'hFF;
  localparam logic [7:0] HIST_PRESSED  = 8'h00;
  localparam logic [3:0] LOW_NIBBLE_ONES = 4'hF;
  localparam logic [7:0] SEG_BLANK     = 8'hFF;

  typedef enum logic {
    OP_SCAN    = 1'b0,
    OP_REFRESH = 1'b1
  } op_t;

  // merged lane outcome for one scan transaction
  typedef struct packed {
    logic       press;
    logic [3:0] key;
  } merge_t;

  // one result transaction
  typedef struct packed {
    logic       press_event;
    logic [3:0] key_index;
    logic [3:0] row_drive;
    logic [2:0] digit_select;
    logic [7:0] segments;
  } res_t;

  // active-low hex glyphs
  function automatic logic [7:0] glyph(input logic [3:0] val);
    logic [7:0] seg;
    unique case (val)
      4'h0: seg = 8'hC0;
      4'h1: seg = 8'hF9;
      4'h2: seg = 8'hA4;
      4'h3: seg = 8'hB0;
      4'h4: seg = 8'h99;
      4'h5: seg = 8'h92;
      4'h6: seg = 8'h82;
      4'h7: seg = 8'hF8;
      4'h8: seg = 8'h80;
      4'h9: seg = 8'h90;
      4'hA: seg = 8'h88;
      4'hB: seg = 8'h83;
      4'hC: seg = 8'hC6;
      4'hD: seg = 8'hA1;
      4'hE: seg = 8'h86;
      default: seg = 8'h8E;
    endcase
    return seg;
  endfunction

endpackage

// ===== sv/mkp_lane.sv =====
// one column lane: sample history per row and debounce decision
`timescale 1ns / 1ps
module mkp_lane
  import mkp_pkg::*;
#(
  parameter int NUM_ROWS = DEFAULT_NUM_ROWS,
  localparam int ROW_W   = $clog2(NUM_ROWS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [ROW_W-1:0] row,
  input  logic             sample,
  output logic             press
);

  logic [7:0] hist [NUM_ROWS];
  logic [7:0] shifted;
  logic [7:0] hist_next;

  // shift in the new sample and classify the last four
  always_comb begin
    shifted   = {hist[row][6:0], sample};
    press     = 1'b0;
    hist_next = shifted;
    if (shifted[3:0] == 4'h0) begin
      press     = (shifted != HIST_PRESSED);
      hist_next = HIST_PRESSED;
    end else if (shifted[3:0] == LOW_NIBBLE_ONES) begin
      hist_next = HIST_RELEASED;
    end
  end

  // history storage, released at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        hist[r] <= HIST_RELEASED;
      end
    end else if (en) begin
      hist[row] <= hist_next;
    end
  end

endmodule

// ===== sv/mkp_merge.sv =====
// merge of lane presses: highest pressed column latches the key index
`timescale 1ns / 1ps
module mkp_merge
  import mkp_pkg::*;
#(
  parameter int NUM_ROWS = DEFAULT_NUM_ROWS,
  localparam int ROW_W   = $clog2(NUM_ROWS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [ROW_W-1:0] row,
  input  logic [COLS-1:0]  press,
  output merge_t           outcome,
  output logic [3:0]       latched_key
);

  logic [1:0]     col;
  logic           hit;
  logic [ROW_W+1:0] idx_wide;
  logic [ROW_W+2:0] idx_ext;
  logic [3:0]     latched_key_next;

  // highest pressed column wins
  always_comb begin
    hit = 1'b0;
    col = 2'd0;
    for (int j = 0; j < COLS; j++) begin
      if (press[j]) begin
        hit = 1'b1;
        col = 2'(j);
      end
    end
    idx_wide         = {row, col};
    idx_ext          = {1'b0, idx_wide};
    latched_key_next = hit ? idx_ext[3:0] : latched_key;
    outcome.press    = hit;
    outcome.key      = latched_key_next;
  end

  // latched key register
  always_ff @(posedge clk) begin
    if (rst) begin
      latched_key <= 4'd0;
    end else if (en) begin
      latched_key <= latched_key_next;
    end
  end

endmodule

// ===== sv/mkp_disp.sv =====
// seven-segment digit multiplexer
`timescale 1ns / 1ps
module mkp_disp
  import mkp_pkg::*;
#(
  parameter int NUM_DIGITS = DEFAULT_NUM_DIGITS,
  localparam int DIG_W     = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic [3:0] latched_key,
  output logic [2:0] digit,
  output logic [7:0] seg
);

  logic [DIG_W-1:0] display_digit;
  logic [DIG_W-1:0] display_digit_next;

  // glyph for the current digit and the wrap of the counter
  always_comb begin
    digit = 3'(display_digit);
    seg   = (display_digit == '0) ? glyph(latched_key) : glyph(4'h0);
    if (display_digit == DIG_W'(NUM_DIGITS - 1)) begin
      display_digit_next = '0;
    end else begin
      display_digit_next = display_digit + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      display_digit <= '0;
    end else if (en) begin
      display_digit <= display_digit_next;
    end
  end

endmodule

// ===== sv/matrix_keypad_scan_with_display.sv =====
// top level: keypad scanner lanes, merge, display multiplexer and output skid
// A result is registered into the output register, or the skid entry, when its input transaction is accepted.
// Throughput: one transaction per cycle while in_ready is high; the four column lanes debounce a row in parallel.
// A two-entry output register and skid stage keeps input flowing while a result waits.
// Reset (synchronous, active high): histories all ones, row, key and digit zero,
// output empty; no clearing pass is needed.
`timescale 1ns / 1ps
module matrix_keypad_scan_with_display
  import mkp_pkg::*;
#(
  parameter int NUM_DIGITS = DEFAULT_NUM_DIGITS,
  parameter int NUM_ROWS   = DEFAULT_NUM_ROWS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       operation,
  input  logic [3:0] column_sample,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       press_event,
  output logic [3:0] key_index,
  output logic [3:0] row_drive,
  output logic [2:0] digit_select,
  output logic [7:0] segments
);

  localparam int ROW_W = $clog2(NUM_ROWS);

  logic             push;
  logic             pop;
  logic             scan_en;
  logic             refresh_en;
  logic [ROW_W-1:0] scan_row;
  logic [ROW_W-1:0] scan_row_next;
  logic [3:0]       row_ext;
  logic [3:0]       next_drive;
  logic [COLS-1:0]  lane_press;
  merge_t           outcome;
  logic [3:0]       latched_key;
  logic [2:0]       disp_digit;
  logic [7:0]       disp_seg;
  res_t             res;
  res_t             main_q;
  res_t             skid_q;
  logic             main_v;
  logic             skid_v;

  assign push       = in_valid && in_ready;
  assign pop        = main_v && out_ready;
  assign scan_en    = push && (op_t'(operation) == OP_SCAN);
  assign refresh_en = push && (op_t'(operation) == OP_REFRESH);

  // column lanes
  for (genvar j = 0; j < COLS; j++) begin : g_lane
    mkp_lane #(.NUM_ROWS(NUM_ROWS)) u_lane (
      .clk    (clk),
      .rst    (rst),
      .en     (scan_en),
      .row    (scan_row),
      .sample (column_sample[j]),
      .press  (lane_press[j])
    );
  end

  mkp_merge #(.NUM_ROWS(NUM_ROWS)) u_merge (
    .clk         (clk),
    .rst         (rst),
    .en          (scan_en),
    .row         (scan_row),
    .press       (lane_press),
    .outcome     (outcome),
    .latched_key (latched_key)
  );

  mkp_disp #(.NUM_DIGITS(NUM_DIGITS)) u_disp (
    .clk         (clk),
    .rst         (rst),
    .en          (refresh_en),
    .latched_key (latched_key),
    .digit       (disp_digit),
    .seg         (disp_seg)
  );

  // row counter and the drive of the row left selected
  always_comb begin
    scan_row_next = scan_row;
    if (scan_en) begin
      scan_row_next = (scan_row == ROW_W'(NUM_ROWS - 1)) ? '0 : scan_row + 1'b1;
    end
    row_ext = 4'(scan_row_next);
    for (int r = 0; r < 4; r++) begin
      next_drive[r] = (row_ext != 4'(r));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row <= '0;
    end else begin
      scan_row <= scan_row_next;
    end
  end

  // result assembly
  always_comb begin
    res.digit_select = disp_digit;
    res.row_drive    = next_drive;
    if (op_t'(operation) == OP_SCAN) begin
      res.press_event = outcome.press;
      res.key_index   = outcome.key;
      res.segments    = SEG_BLANK;
    end else begin
      res.press_event = 1'b0;
      res.key_index   = latched_key;
      res.segments    = disp_seg;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (pop && skid_v) begin
        main_q <= skid_q;
        skid_v <= push;
        if (push) begin
          skid_q <= res;
        end
      end else if (pop) begin
        main_v <= push;
        if (push) begin
          main_q <= res;
        end
      end else if (push) begin
        if (!main_v) begin
          main_q <= res;
          main_v <= 1'b1;
        end else begin
          skid_q <= res;
          skid_v <= 1'b1;
        end
      end
    end
  end

  assign in_ready     = !skid_v;
  assign out_valid    = main_v;
  assign press_event  = main_q.press_event;
  assign key_index    = main_q.key_index;
  assign row_drive    = main_q.row_drive;
  assign digit_select = main_q.digit_select;
  assign segments     = main_q.segments;

  // skid entry is only used behind a held main entry
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> main_v)
    else $error("skid entry holds a result while the output register is empty");

  // at most one row is driven low
  a_one_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($countones(~row_drive) <= 1))
    else $error("more than one row driven low");

  // presses come only from scan transactions, which blank the display fields
  a_press_blank: assert property (@(posedge clk) disable iff (rst)
    (out_valid && press_event) |-> (segments == SEG_BLANK))
    else $error("press reported on a refresh result");

  // a press updates the latched key with a key on the scanned row
  a_press_row: assert property (@(posedge clk) disable iff (rst)
    (scan_en && outcome.press) |=> (latched_key == $past(outcome.key)))
    else $error("latched key not updated on a press");

endmodule
